FILE: sv/sqlx_pkg.sv
package sqlx_pkg;

   // Lexer modes
   localparam logic [3:0] M_IDLE      = 4'd0;
   localparam logic [3:0] M_WORD      = 4'd1;
   localparam logic [3:0] M_NUM_INT   = 4'd2;
   localparam logic [3:0] M_NUM_FRAC  = 4'd3;
   localparam logic [3:0] M_STR       = 4'd4;
   localparam logic [3:0] M_STR_ESC   = 4'd5;
   localparam logic [3:0] M_LINE      = 4'd6;
   localparam logic [3:0] M_BLK_SKIP  = 4'd7;
   localparam logic [3:0] M_BLK       = 4'd8;
   localparam logic [3:0] M_BLK_CLOSE = 4'd9;
   localparam logic [3:0] M_SYM2      = 4'd10;

   // Token kinds
   localparam logic [2:0] K_WS      = 3'd0;
   localparam logic [2:0] K_WORD    = 3'd1;
   localparam logic [2:0] K_NUM     = 3'd2;
   localparam logic [2:0] K_STR     = 3'd3;
   localparam logic [2:0] K_SYM     = 3'd4;
   localparam logic [2:0] K_COMMENT = 3'd5;

   // Quote kinds
   localparam logic [1:0] Q_NONE   = 2'd0;
   localparam logic [1:0] Q_SINGLE = 2'd1;
   localparam logic [1:0] Q_DOUBLE = 2'd2;
   localparam logic [1:0] Q_BTICK  = 2'd3;

   // Character codes
   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_LF         = 8'h0A;
   localparam logic [7:0] CH_CR         = 8'h0D;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_BANG       = 8'h21;
   localparam logic [7:0] CH_DQUOTE     = 8'h22;
   localparam logic [7:0] CH_SQUOTE     = 8'h27;
   localparam logic [7:0] CH_STAR       = 8'h2A;
   localparam logic [7:0] CH_DASH       = 8'h2D;
   localparam logic [7:0] CH_DOT        = 8'h2E;
   localparam logic [7:0] CH_SLASH      = 8'h2F;
   localparam logic [7:0] CH_ZERO       = 8'h30;
   localparam logic [7:0] CH_NINE       = 8'h39;
   localparam logic [7:0] CH_COLON      = 8'h3A;
   localparam logic [7:0] CH_LT         = 8'h3C;
   localparam logic [7:0] CH_EQ         = 8'h3D;
   localparam logic [7:0] CH_GT         = 8'h3E;
   localparam logic [7:0] CH_UP_A       = 8'h41;
   localparam logic [7:0] CH_UP_Z       = 8'h5A;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_BTICK      = 8'h60;
   localparam logic [7:0] CH_LO_A       = 8'h61;
   localparam logic [7:0] CH_LO_Z       = 8'h7A;
   localparam logic [7:0] CH_PIPE       = 8'h7C;
   localparam logic [7:0] CASE_OFFSET   = 8'h20;

   typedef struct packed {
      logic [7:0] char_in;
      logic       last_in;
   } req_type;

   typedef struct packed {
      logic [7:0] byte_out;
      logic [7:0] upper_byte;
      logic [2:0] token_kind;
      logic       token_start;
      logic       last_out;
   } rsp_type;

   // Results one accepted item pushes toward the output queue
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       start;
      logic [3:0] mode;
      logic [1:0] quote;
   } disp_type;

   typedef struct packed {
      rsp_type    rsp;
      logic [3:0] mode;
      logic [1:0] quote;
   } lbl_type;

   function automatic logic is_digit(logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_ident_start(logic [7:0] c);
      return ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z))
             || (c == CH_UNDERSCORE);
   endfunction

   function automatic logic is_ident(logic [7:0] c);
      return is_ident_start(c) || is_digit(c);
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
   endfunction

   // Two-byte operators: <= >= <> != || ::
   function automatic logic is_op_pair(logic [7:0] a, logic [7:0] b);
      return ((a == CH_LT) && (b == CH_EQ)) || ((a == CH_GT) && (b == CH_EQ))
             || ((a == CH_LT) && (b == CH_GT)) || ((a == CH_BANG) && (b == CH_EQ))
             || ((a == CH_PIPE) && (b == CH_PIPE)) || ((a == CH_COLON) && (b == CH_COLON));
   endfunction

   function automatic logic [7:0] quote_char(logic [1:0] q);
      logic [7:0] c;
      unique case (q)
         Q_NONE, Q_SINGLE: c = CH_SQUOTE;
         Q_DOUBLE:         c = CH_DQUOTE;
         default:          c = CH_BTICK;
      endcase
      return c;
   endfunction

   // Classify a byte that opens a fresh token
   function automatic disp_type lex_dispatch(logic [7:0] b, logic hn, logic [7:0] nx,
                                             logic [1:0] quote);
      disp_type d;
      d.kind  = K_SYM;
      d.start = 1'b1;
      d.mode  = M_IDLE;
      d.quote = quote;
      if (is_space(b)) begin
         d.kind  = K_WS;
         d.start = 1'b0;
      end else if ((b == CH_DASH) && hn && (nx == CH_DASH)) begin
         d.kind = K_COMMENT;
         d.mode = M_LINE;
      end else if ((b == CH_SLASH) && hn && (nx == CH_STAR)) begin
         d.kind = K_COMMENT;
         d.mode = M_BLK_SKIP;
      end else if ((b == CH_SQUOTE) || (b == CH_DQUOTE) || (b == CH_BTICK)) begin
         d.kind  = K_STR;
         d.mode  = M_STR;
         d.quote = (b == CH_SQUOTE) ? Q_SINGLE : ((b == CH_DQUOTE) ? Q_DOUBLE : Q_BTICK);
      end else if (is_ident_start(b)) begin
         d.kind = K_WORD;
         d.mode = M_WORD;
      end else if (is_digit(b)) begin
         d.kind = K_NUM;
         d.mode = M_NUM_INT;
      end else if (hn && is_op_pair(b, nx)) begin
         d.mode = M_SYM2;
      end
      return d;
   endfunction

   // Label one byte given the mode it meets and one byte of lookahead
   function automatic lbl_type lex_label(logic [3:0] mode, logic [1:0] quote, logic [7:0] b,
                                         logic hn, logic [7:0] nx, logic last);
      lbl_type    r;
      disp_type   d;
      logic [7:0] q;
      logic [2:0] kind;
      logic       start;
      d     = lex_dispatch(b, hn, nx, quote);
      q     = quote_char(quote);
      kind  = K_WS;
      start = 1'b0;
      r.mode  = mode;
      r.quote = quote;
      unique case (mode)
         M_WORD: begin
            if (is_ident(b)) begin
               kind = K_WORD;
            end else begin
               kind = d.kind; start = d.start; r.mode = d.mode; r.quote = d.quote;
            end
         end
         M_NUM_INT: begin
            if (is_digit(b)) begin
               kind = K_NUM;
            end else if ((b == CH_DOT) && hn && is_digit(nx)) begin
               kind   = K_NUM;
               r.mode = M_NUM_FRAC;
            end else begin
               kind = d.kind; start = d.start; r.mode = d.mode; r.quote = d.quote;
            end
         end
         M_NUM_FRAC: begin
            if (is_digit(b)) begin
               kind = K_NUM;
            end else begin
               kind = d.kind; start = d.start; r.mode = d.mode; r.quote = d.quote;
            end
         end
         M_STR: begin
            kind = K_STR;
            if (b == q) begin
               r.mode = (hn && (nx == q)) ? M_STR_ESC : M_IDLE;
            end
         end
         M_STR_ESC: begin
            kind   = K_STR;
            r.mode = M_STR;
         end
         M_LINE: begin
            if (b == CH_LF) begin
               kind = d.kind; start = d.start; r.mode = d.mode; r.quote = d.quote;
            end else begin
               kind = K_COMMENT;
            end
         end
         M_BLK_SKIP: begin
            kind   = K_COMMENT;
            r.mode = M_BLK;
         end
         M_BLK: begin
            kind = K_COMMENT;
            if ((b == CH_STAR) && hn && (nx == CH_SLASH)) begin
               r.mode = M_BLK_CLOSE;
            end
         end
         M_BLK_CLOSE: begin
            kind   = K_COMMENT;
            r.mode = M_IDLE;
         end
         M_SYM2: begin
            kind   = K_SYM;
            r.mode = M_IDLE;
         end
         default: begin
            kind = d.kind; start = d.start; r.mode = d.mode; r.quote = d.quote;
         end
      endcase
      r.rsp.byte_out    = b;
      r.rsp.upper_byte  = ((kind == K_WORD) && (b >= CH_LO_A) && (b <= CH_LO_Z))
                          ? (b - CASE_OFFSET) : b;
      r.rsp.token_kind  = kind;
      r.rsp.token_start = start;
      r.rsp.last_out    = last;
      return r;
   endfunction

endpackage

FILE: sv/sql_lexer_byte_classifier.sv
// Channel  Direction  Payload                                        Handshake
// req_     in         char_in, last_in                               req_valid / req_ready
// rsp_     out        byte_out, upper_byte, token_kind, token_start,  rsp_valid / rsp_ready
//                     last_out
//
// One item is taken per cycle while req_ready is high; its labels reach rsp_ through a
// three-slot result queue. A byte is labelled when the next byte arrives, so an item
// yields no result, one, or two (the final byte flushes the held one too); a final item
// with a held byte thus pushes two results. req_ready falls only when the queue
// cannot take two more results. Reset (synchronous) empties the queue and drops the held byte.
module sql_lexer_byte_classifier (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sqlx_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sqlx_pkg::rsp_type rsp_data
);
   import sqlx_pkg::*;

   push_type push;
   logic     accept;

   assign accept = req_valid && req_ready;

   sqlx_lexer u_lexer (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .push     (push)
   );

   sqlx_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: sv/sqlx_lexer.sv
module sqlx_lexer (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  sqlx_pkg::req_type req_data,
   output sqlx_pkg::push_type push
);
   import sqlx_pkg::*;

   logic [7:0] held_byte_ff, held_byte_in;
   logic       held_valid_ff, held_valid_in;
   logic [3:0] mode_ff, mode_in;
   logic [1:0] quote_ff, quote_in;

   lbl_type    held_lbl;
   lbl_type    last_lbl;
   logic [3:0] mid_mode;
   logic [1:0] mid_quote;

   // Label the held byte against the new one, then the new one if it ends the text
   always_comb begin
      held_lbl  = lex_label(mode_ff, quote_ff, held_byte_ff, 1'b1, req_data.char_in, 1'b0);
      mid_mode  = held_valid_ff ? held_lbl.mode  : mode_ff;
      mid_quote = held_valid_ff ? held_lbl.quote : quote_ff;
      last_lbl  = lex_label(mid_mode, mid_quote, req_data.char_in, 1'b0, 8'h00, 1'b1);
   end

   // Pack the results of this item
   always_comb begin
      push.count  = accept ? ({1'b0, held_valid_ff} + {1'b0, req_data.last_in}) : 2'd0;
      push.first  = held_valid_ff ? held_lbl.rsp : last_lbl.rsp;
      push.second = last_lbl.rsp;
   end

   // Hold the new byte, or drop everything at the end of the text
   always_comb begin
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      mode_in       = mode_ff;
      quote_in      = quote_ff;
      if (accept) begin
         if (req_data.last_in) begin
            held_byte_in  = 8'h00;
            held_valid_in = 1'b0;
            mode_in       = M_IDLE;
            quote_in      = Q_NONE;
         end else begin
            held_byte_in  = req_data.char_in;
            held_valid_in = 1'b1;
            mode_in       = mid_mode;
            quote_in      = mid_quote;
         end
      end
   end

   always_ff @(posedge clock) begin
      held_byte_ff <= held_byte_in;
      if (reset) begin
         held_valid_ff <= 1'b0;
         mode_ff       <= M_IDLE;
         quote_ff      <= Q_NONE;
      end else begin
         held_valid_ff <= held_valid_in;
         mode_ff       <= mode_in;
         quote_ff      <= quote_in;
      end
   end

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.last_in |=> !held_valid_ff && (mode_ff == M_IDLE))
      else $error("lexer state not cleared after final byte");

   a_hold_new: assert property (@(posedge clock) disable iff (reset)
      accept && !req_data.last_in |=> held_valid_ff
                                      && (held_byte_ff == $past(req_data.char_in)))
      else $error("new byte not held");

endmodule

FILE: sv/sqlx_rsp_queue.sv
module sqlx_rsp_queue (
   input  logic               clock,
   input  logic               reset,
   input  sqlx_pkg::push_type push,
   output logic               room,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output sqlx_pkg::rsp_type  rsp_data
);
   import sqlx_pkg::*;

   localparam logic [1:0] LAST_SLOT = 2'd2;

   rsp_type    slots_ff [3];
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] count_ff, count_in;
   logic [1:0] wr_next;
   logic       pop;

   function automatic logic [1:0] ptr_inc(logic [1:0] p);
      return (p == LAST_SLOT) ? 2'd0 : (p + 2'd1);
   endfunction

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = slots_ff[rd_ptr_ff];
   // Take an item only when both of its possible results fit after this pop
   assign room      = (count_ff < 2'd2) || ((count_ff == 2'd2) && rsp_ready);
   assign wr_next   = ptr_inc(wr_ptr_ff);

   // Advance pointers and fill count
   always_comb begin
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      unique case (push.count)
         2'd1:    wr_ptr_in = wr_next;
         2'd2:    wr_ptr_in = ptr_inc(wr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      count_in = count_ff + push.count - {1'b0, pop};
   end

   // Write up to two results
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         slots_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         slots_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 2'd0;
         wr_ptr_ff <= 2'd0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> ({1'b0, count_ff} + {1'b0, push.count} - {2'b0, pop}) <= 3'd3)
      else $error("result queue overflow");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      pop && (push.count == 2'd0) |=> count_ff == $past(count_ff) - 2'd1)
      else $error("queue count wrong after pop");

   a_push_two: assert property (@(posedge clock) disable iff (reset)
      !pop && (push.count == 2'd2) |=> count_ff == $past(count_ff) + 2'd2)
      else $error("queue count wrong after double push");

endmodule
